/* hdl/sit_pkg.sv */
package sit_pkg;

  localparam int DEF_ENTRIES   = 128;
  localparam int DEF_MAX_CHARS = 128;

  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_ADDED    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SRCH,
    S_SWAIT,
    S_WRITE
  } state_t;

endpackage

/* hdl/sit_cell.sv */
module sit_cell import sit_pkg::*; #(
  parameter int ENTRIES   = DEF_ENTRIES,
  parameter int MAX_CHARS = DEF_MAX_CHARS,
  parameter int IDX       = 0,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CW = $clog2(MAX_CHARS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_vld,
  input  logic          in_last,
  input  logic          in_wr,
  input  logic [7:0]    in_ch,
  input  logic [CW-1:0] in_pos,
  input  logic [IW-1:0] in_tgt,
  input  logic          in_hit,
  input  logic [IW-1:0] in_hidx,
  output logic          out_vld,
  output logic          out_last,
  output logic          out_wr,
  output logic [7:0]    out_ch,
  output logic [CW-1:0] out_pos,
  output logic [IW-1:0] out_tgt,
  output logic          out_hit,
  output logic [IW-1:0] out_hidx
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [7:0]    mem [MAX_CHARS];
  logic [7:0]    rdata;
  logic [CW-1:0] len;
  logic          used;
  logic          mism;
  logic          t_vld, t_last, t_wr, t_hit;
  logic [7:0]    t_ch;
  logic [CW-1:0] t_pos;
  logic [IW-1:0] t_tgt, t_hidx;
  logic          match;
  logic          wr_here;

  assign wr_here = in_vld && in_wr && (in_tgt == MY_IDX);

  always_ff @(posedge clk) begin
    rdata <= mem[in_pos];
    if (wr_here && !in_last) begin
      mem[in_pos] <= in_ch;
    end
    if (wr_here && in_last) begin
      len <= in_pos;
    end
    t_last <= in_last;
    t_wr   <= in_wr;
    t_ch   <= in_ch;
    t_pos  <= in_pos;
    t_tgt  <= in_tgt;
    t_hit  <= in_hit;
    t_hidx <= in_hidx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_vld <= 1'b0;
      used  <= 1'b0;
      mism  <= 1'b0;
    end else begin
      t_vld <= in_vld;
      if (wr_here && in_last) begin
        used <= 1'b1;
      end
      if (t_vld && t_last) begin
        mism <= 1'b0;
      end else if (t_vld && !t_wr) begin
        mism <= mism | (rdata != t_ch);
      end
    end
  end

  assign match = used && (len == t_pos) && !mism;

  always_comb begin
    out_vld  = t_vld;
    out_last = t_last;
    out_wr   = t_wr;
    out_ch   = t_ch;
    out_pos  = t_pos;
    out_tgt  = t_tgt;
    out_hit  = t_hit;
    out_hidx = t_hidx;
    if (t_vld && t_last && !t_wr && !t_hit && match) begin
      out_hit  = 1'b1;
      out_hidx = MY_IDX;
    end
  end

endmodule

/* hdl/string_intern_table_unit.sv */
// String intern table.
// Input: char_byte is taken at a clock edge with start high and busy low.
// Nonzero bytes build the key, one per cycle, with no result. A zero byte
// ends the key and raises busy while the key is matched against the stored
// entries.
// Each stored entry lives in one cell of a chain; the key streams through
// the chain one character per cycle, each cell compares it with its own
// entry and passes it on. A search result shows once the key has passed
// through every cell; adding a new entry then streams the key through the
// chain once more, to the next free cell.
// An overlong key is answered in the cycle after its terminator is taken.
// Result: done pulses for one cycle with entry_index, status and
// entry_count; the receiver cannot stall, so each result is shown once.
// Reset empties the table and the key buffer; entry storage itself is not
// cleared, cells are marked unused.
module string_intern_table_unit import sit_pkg::*; #(
  parameter int ENTRIES   = DEF_ENTRIES,
  parameter int MAX_CHARS = DEF_MAX_CHARS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] char_byte,
  output logic       busy,
  output logic       done,
  output logic [6:0] entry_index,
  output logic [1:0] status,
  output logic [7:0] entry_count
);

  localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW   = $clog2(MAX_CHARS);
  localparam int CNTW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0]   KEY_MAX  = CW'(MAX_CHARS - 1);
  localparam logic [CNTW-1:0] CNT_FULL = CNTW'(ENTRIES);

  state_t state, state_next;

  logic [7:0]    kbuf [MAX_CHARS];
  logic [7:0]    kb_rdata;
  logic [CW-1:0] klen;
  logic          ovf;
  logic [CW-1:0] rd_ptr;
  logic [CNTW-1:0] cnt;
  logic          pend_vld, pend_last, pend_wr;
  logic [CW-1:0] pend_pos;
  logic [IW-1:0] pend_tgt;
  logic          issue_end;
  logic          accept;

  logic          c_vld  [ENTRIES+1];
  logic          c_last [ENTRIES+1];
  logic          c_wr   [ENTRIES+1];
  logic [7:0]    c_ch   [ENTRIES+1];
  logic [CW-1:0] c_pos  [ENTRIES+1];
  logic [IW-1:0] c_tgt  [ENTRIES+1];
  logic          c_hit  [ENTRIES+1];
  logic [IW-1:0] c_hidx [ENTRIES+1];

  logic          res_end;
  logic [31:0]   hidx_w;
  logic [31:0]   cnt_w;
  logic [31:0]   cnt_inc_w;

  assign accept    = start && !busy;
  assign issue_end = (rd_ptr == klen);
  assign res_end   = c_vld[ENTRIES] && c_last[ENTRIES] && !c_wr[ENTRIES];
  assign hidx_w    = 32'(c_hidx[ENTRIES]);
  assign cnt_w     = 32'(cnt);
  assign cnt_inc_w = 32'(cnt) + 32'd1;

  assign c_vld[0]  = pend_vld;
  assign c_last[0] = pend_last;
  assign c_wr[0]   = pend_wr;
  assign c_ch[0]   = kb_rdata;
  assign c_pos[0]  = pend_pos;
  assign c_tgt[0]  = pend_tgt;
  assign c_hit[0]  = 1'b0;
  assign c_hidx[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    sit_cell #(
      .ENTRIES  (ENTRIES),
      .MAX_CHARS(MAX_CHARS),
      .IDX      (g)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .in_vld  (c_vld[g]),
      .in_last (c_last[g]),
      .in_wr   (c_wr[g]),
      .in_ch   (c_ch[g]),
      .in_pos  (c_pos[g]),
      .in_tgt  (c_tgt[g]),
      .in_hit  (c_hit[g]),
      .in_hidx (c_hidx[g]),
      .out_vld (c_vld[g+1]),
      .out_last(c_last[g+1]),
      .out_wr  (c_wr[g+1]),
      .out_ch  (c_ch[g+1]),
      .out_pos (c_pos[g+1]),
      .out_tgt (c_tgt[g+1]),
      .out_hit (c_hit[g+1]),
      .out_hidx(c_hidx[g+1])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && char_byte == 8'd0 && !ovf) begin
          state_next = S_SRCH;
        end
      end
      S_SRCH: begin
        if (issue_end) begin
          state_next = S_SWAIT;
        end
      end
      S_SWAIT: begin
        if (res_end) begin
          if (c_hit[ENTRIES] || cnt == CNT_FULL) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        if (issue_end) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != S_IDLE);
  end

  always_ff @(posedge clk) begin
    kb_rdata <= kbuf[rd_ptr];
    if (accept && char_byte != 8'd0 && !ovf && klen != KEY_MAX) begin
      kbuf[klen] <= char_byte;
    end
    pend_pos <= issue_end ? klen : rd_ptr;
    pend_last <= issue_end;
    pend_wr <= (state == S_WRITE);
    pend_tgt <= cnt[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      klen     <= '0;
      ovf      <= 1'b0;
      rd_ptr   <= '0;
      cnt      <= '0;
      pend_vld <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      done     <= 1'b0;
      pend_vld <= (state == S_SRCH) || (state == S_WRITE);
      if (state == S_SRCH || state == S_WRITE) begin
        rd_ptr <= issue_end ? '0 : rd_ptr + CW'(1);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (char_byte != 8'd0) begin
              if (!ovf) begin
                if (klen == KEY_MAX) begin
                  ovf <= 1'b1;
                end else begin
                  klen <= klen + CW'(1);
                end
              end
            end else if (ovf) begin
              done        <= 1'b1;
              entry_index <= 7'd0;
              status      <= ST_TOO_LONG;
              entry_count <= cnt_w[7:0];
              ovf         <= 1'b0;
              klen        <= '0;
            end else begin
              rd_ptr <= '0;
            end
          end
        end
        S_SWAIT: begin
          if (res_end) begin
            if (c_hit[ENTRIES]) begin
              done        <= 1'b1;
              entry_index <= hidx_w[6:0];
              status      <= ST_FOUND;
              entry_count <= cnt_w[7:0];
              klen        <= '0;
            end else if (cnt == CNT_FULL) begin
              done        <= 1'b1;
              entry_index <= 7'd0;
              status      <= ST_FULL;
              entry_count <= cnt_w[7:0];
              klen        <= '0;
            end
          end
        end
        S_WRITE: begin
          if (issue_end) begin
            done        <= 1'b1;
            entry_index <= cnt_w[6:0];
            status      <= ST_ADDED;
            entry_count <= cnt_inc_w[7:0];
            cnt         <= cnt + CNTW'(1);
            klen        <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
